// ===== rtl/mssc_pkg.sv =====
// ----------------------------------------------------------------------------
// mssc_pkg: shared types and constants of the seven-segment counter
// Holds field widths, configuration register indexes, the digit view
// handed from the digit logic to the top level and the segment table.
// ----------------------------------------------------------------------------
package mssc_pkg;

  localparam int unsigned PERIOD_W   = 16;
  localparam int unsigned COUNT_W    = 14;
  localparam int unsigned DIGITS     = 4;
  localparam int unsigned SEG_W      = 8;
  localparam int unsigned IDX_W      = 2;
  localparam int unsigned BCD_W      = 4;

  localparam logic [COUNT_W-1:0]  COUNT_MAX    = 14'd9999;
  localparam logic [BCD_W-1:0]    BCD_MAX      = 4'd9;
  localparam logic [PERIOD_W-1:0] COUNT_PERIOD_RST = 16'd100;
  localparam logic [PERIOD_W-1:0] SCAN_PERIOD_RST  = 16'd4;
  localparam logic [DIGITS-1:0]   DOT_RING_RST = 4'b0001;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_COUNT_PERIOD = 1'b0,
    CFG_SCAN_PERIOD  = 1'b1
  } cfg_idx_t;

  typedef logic [SEG_W-1:0] seg_t;

  // Counter value and the digit patterns as they stand after this transfer
  typedef struct packed {
    logic [COUNT_W-1:0]           count;
    logic [DIGITS-1:0][SEG_W-1:0] patterns;
  } digit_view_t;

  // Segments a..g in bits 0..6; decimal point is added separately
  function automatic seg_t seg_code(input logic [BCD_W-1:0] d);
    seg_t s;
    case (d)
      4'd0:    s = 8'h3f;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5b;
      4'd3:    s = 8'h4f;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6d;
      4'd6:    s = 8'h7d;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7f;
      4'd9:    s = 8'h6f;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/mssc_if.sv =====
// ----------------------------------------------------------------------------
// mssc_if: valid/ready channels of the seven-segment counter
// Input channel carries the millisecond tick, output channel the display
// drives and the counter value.
// ----------------------------------------------------------------------------
interface mssc_in_if;
  logic valid;
  logic ready;
  logic tick;

  modport source (output valid, output tick, input ready);
  modport sink   (input valid, input tick, output ready);
endinterface

interface mssc_out_if;
  logic                          valid;
  logic                          ready;
  logic [3:0]                    digit_enable_n;
  logic [mssc_pkg::SEG_W-1:0]    segment_drive;
  logic [mssc_pkg::COUNT_W-1:0]  count_value;

  modport source (output valid, output digit_enable_n, output segment_drive,
                  output count_value, input ready);
  modport sink   (input valid, input digit_enable_n, input segment_drive,
                  input count_value, output ready);
endinterface

// ===== rtl/mssc_timer.sv =====
// ----------------------------------------------------------------------------
// mssc_timer: millisecond period timer
// Counts ticks and fires once the elapsed count reaches the period, then
// subtracts the period. A zero period fires on every tick.
// ----------------------------------------------------------------------------
module mssc_timer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          tick_en,
  input  logic [mssc_pkg::PERIOD_W-1:0] period,
  output logic                          fire
);

  logic [mssc_pkg::PERIOD_W-1:0] elapsed_r;
  logic [mssc_pkg::PERIOD_W-1:0] elapsed_nxt;
  logic [mssc_pkg::PERIOD_W:0]   inc;
  logic [mssc_pkg::PERIOD_W:0]   rem;

  always_comb begin
    inc  = {1'b0, elapsed_r} + {{mssc_pkg::PERIOD_W{1'b0}}, 1'b1};
    fire = tick_en && (inc >= {1'b0, period});
    rem  = fire ? (inc - {1'b0, period}) : inc;
    // saturate: only reachable with a zero period
    if (rem[mssc_pkg::PERIOD_W]) begin
      elapsed_nxt = '1;
    end else begin
      elapsed_nxt = rem[mssc_pkg::PERIOD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      elapsed_r <= '0;
    end else if (tick_en) begin
      elapsed_r <= elapsed_nxt;
    end
  end

endmodule

// ===== rtl/mssc_digits.sv =====
// ----------------------------------------------------------------------------
// mssc_digits: decimal counter and digit pattern store
// Keeps the counter both in binary and as four BCD digits, rebuilds the
// four segment patterns on each count and rotates the dot ring.
// ----------------------------------------------------------------------------
module mssc_digits (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       count_fire,
  output mssc_pkg::digit_view_t      view_nxt,
  output logic [mssc_pkg::COUNT_W-1:0] count_value
);

  localparam int unsigned ND = mssc_pkg::DIGITS;

  logic [mssc_pkg::COUNT_W-1:0]             count_r;
  logic [mssc_pkg::COUNT_W-1:0]             count_nxt;
  logic [ND-1:0][mssc_pkg::BCD_W-1:0]       bcd_r;
  logic [ND-1:0][mssc_pkg::BCD_W-1:0]       bcd_nxt;
  logic [ND-1:0][mssc_pkg::SEG_W-1:0]       pat_r;
  logic [ND-1:0][mssc_pkg::SEG_W-1:0]       pat_nxt;
  logic [ND-1:0]                            ring_r;
  logic [ND:0]                              carry;

  // digit 0 is thousands, digit ND-1 is units; carry ripples from units up
  always_comb begin
    carry[ND] = 1'b1;
    for (int i = ND - 1; i >= 0; i--) begin
      if (!carry[i+1]) begin
        bcd_nxt[i] = bcd_r[i];
        carry[i]   = 1'b0;
      end else if (bcd_r[i] == mssc_pkg::BCD_MAX) begin
        bcd_nxt[i] = '0;
        carry[i]   = 1'b1;
      end else begin
        bcd_nxt[i] = bcd_r[i] + 4'd1;
        carry[i]   = 1'b0;
      end
    end
    count_nxt = (count_r == mssc_pkg::COUNT_MAX) ? '0 : count_r + 14'd1;
    for (int i = 0; i < ND; i++) begin
      pat_nxt[i] = mssc_pkg::seg_code(bcd_nxt[i]) | {ring_r[i], 7'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      bcd_r   <= '0;
      pat_r   <= '0;
      ring_r  <= mssc_pkg::DOT_RING_RST;
    end else if (count_fire) begin
      count_r <= count_nxt;
      bcd_r   <= bcd_nxt;
      pat_r   <= pat_nxt;
      ring_r  <= {ring_r[ND-2:0], ring_r[ND-1]};
    end
  end

  assign view_nxt.count    = count_fire ? count_nxt : count_r;
  assign view_nxt.patterns = count_fire ? pat_nxt : pat_r;
  assign count_value       = count_r;

endmodule

// ===== rtl/multiplexed_seven_segment_counter.sv =====
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_counter: four-digit multiplexed display counter
// Millisecond-tick driven decimal counter with seven-segment multiplexing.
// ----------------------------------------------------------------------------
// Each input transfer carries one tick bit. The block takes one transfer
// per clock and answers each with exactly one output transfer in the next
// cycle; the display registers themselves form the output stage, so the
// input stalls only while a finished result is waiting and out ready is
// low. On a tick the count timer and the scan timer each advance. When
// the count timer reaches count_period the 0..9999 counter advances and
// the four digit patterns (digit 0 = thousands) are rebuilt, with the
// decimal point of digit i taken from bit i of the dot ring before it
// rotates left. When the scan timer reaches scan_period, digit scan_index
// is driven low with its pattern and the index steps 0,1,2,3. If both
// fire on one tick the scan already shows the new patterns. A tick of 0
// changes nothing and repeats the held outputs. After reset all four
// digit enables are low and the segments are blank. Configuration writes
// (cfg_index 0 = count_period, 1 = scan_period) take effect at once and
// are meant to happen while no transfer is in flight.
// ----------------------------------------------------------------------------
module multiplexed_seven_segment_counter #(
  parameter logic [mssc_pkg::PERIOD_W-1:0] COUNT_PERIOD_RST = mssc_pkg::COUNT_PERIOD_RST,
  parameter logic [mssc_pkg::PERIOD_W-1:0] SCAN_PERIOD_RST  = mssc_pkg::SCAN_PERIOD_RST
) (
  input  logic                          clk,
  input  logic                          rst_n,
  mssc_in_if.sink                       in_chan,
  mssc_out_if.source                    out_chan,
  input  logic                          cfg_we,
  input  mssc_pkg::cfg_idx_t            cfg_index,
  input  logic [mssc_pkg::PERIOD_W-1:0] cfg_wdata
);

  logic [mssc_pkg::PERIOD_W-1:0] count_period_r;
  logic [mssc_pkg::PERIOD_W-1:0] scan_period_r;
  logic                          out_valid_r;
  logic [mssc_pkg::IDX_W-1:0]    scan_idx_r;
  logic [mssc_pkg::DIGITS-1:0]   held_en_r;
  mssc_pkg::seg_t                held_seg_r;

  logic                          accept;
  logic                          tick_en;
  logic                          count_fire;
  logic                          scan_fire;
  mssc_pkg::digit_view_t         view_nxt;
  logic [mssc_pkg::COUNT_W-1:0]  count_value;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_period_r <= COUNT_PERIOD_RST;
      scan_period_r  <= SCAN_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mssc_pkg::CFG_COUNT_PERIOD: count_period_r <= cfg_wdata;
        mssc_pkg::CFG_SCAN_PERIOD:  scan_period_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Take a new tick whenever the output stage is empty or being drained
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign accept        = in_chan.valid && in_chan.ready;
  assign tick_en       = accept && in_chan.tick;

  mssc_timer u_count_timer (
    .clk     (clk),
    .rst_n   (rst_n),
    .tick_en (tick_en),
    .period  (count_period_r),
    .fire    (count_fire)
  );

  mssc_timer u_scan_timer (
    .clk     (clk),
    .rst_n   (rst_n),
    .tick_en (tick_en),
    .period  (scan_period_r),
    .fire    (scan_fire)
  );

  mssc_digits u_digits (
    .clk         (clk),
    .rst_n       (rst_n),
    .count_fire  (count_fire),
    .view_nxt    (view_nxt),
    .count_value (count_value)
  );

  // Scan step: drive one digit low with the pattern as of this tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      held_en_r  <= '0;
      held_seg_r <= '0;
    end else if (scan_fire) begin
      held_en_r  <= ~(mssc_pkg::DIGITS'(1) << scan_idx_r);
      held_seg_r <= view_nxt.patterns[scan_idx_r];
      scan_idx_r <= scan_idx_r + 2'd1;
    end
  end

  // Output valid: set by each accepted transfer, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.digit_enable_n = held_en_r;
  assign out_chan.segment_drive  = held_seg_r;
  assign out_chan.count_value    = count_value;

  // Counter never leaves the decimal range
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_value <= mssc_pkg::COUNT_MAX)
    else $error("count value out of range");

  // Either all digits driven (after reset) or exactly one
  a_enable_shape: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(held_en_r) == 3) || (held_en_r == '0))
    else $error("bad digit enable pattern");

  // A scan step advances the index by one
  a_scan_step: assert property (@(posedge clk) disable iff (!rst_n)
    scan_fire |=> (scan_idx_r == $past(scan_idx_r) + 2'd1))
    else $error("scan index did not advance");

  // Timers move only on an accepted tick
  a_fire_needs_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (count_fire || scan_fire) |-> tick_en)
    else $error("timer fired without a tick");

endmodule
